>>> rtl/wrb_pkg.sv
// Package for the work request balancer.
// Holds the transaction types, register indexes, codes and default sizes.
// No dependencies.
package wrb_pkg;

  localparam int DEF_MAX_WORKERS = 16;
  localparam int DEF_LOAD_BITS   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORKERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_THRESHOLD = 2'd2;

  localparam logic [4:0]  RST_ACTIVE_WORKERS   = 5'd16;
  localparam logic [7:0]  RST_REPORT_STEP      = 8'd5;
  localparam logic [15:0] RST_FINISH_THRESHOLD = 16'd75;

  localparam logic ACT_REPORT      = 1'b0;
  localparam logic ACT_REQUEST     = 1'b1;
  localparam logic VERDICT_FINISH  = 1'b0;
  localparam logic VERDICT_FORWARD = 1'b1;

  typedef struct packed {
    logic       action;
    logic [3:0] source;
  } msg_t;

  typedef struct packed {
    logic       verdict;
    logic [3:0] target;
    logic [3:0] requester;
    logic       all_finished;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RPT_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE
  } state_t;

endpackage

>>> rtl/wrb_load_mem.sv
// Load count memory for the work request balancer.
// One write port, one registered read port; per-entry valid bits make
// unwritten entries read as zero after reset. Uses no package items.
module wrb_load_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] ent_valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
      rd_vld <= ent_valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

>>> rtl/work_request_balancer.sv
// Work request balancer, top level.
// Depends on wrb_pkg and wrb_load_mem.
//
// One message is taken at a time; msg_stall stays high while it is handled.
// A report passes the check and report-write states before the next message is
// taken, a message from an unused or finished worker the check state only, a
// request the check, scan (once per active worker), scan-end and decision
// states; load counts sit in a memory with one read port and are compared one
// per cycle against the running minimum. A result waits in an output register
// while the next message is handled; a request cannot complete until that
// register is free. Counts and marks are zero after reset with no clearing pass.
module work_request_balancer #(
  parameter int MAX_WORKERS = wrb_pkg::DEF_MAX_WORKERS,
  parameter int LOAD_BITS   = wrb_pkg::DEF_LOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           msg_valid,
  output logic                           msg_stall,
  input  wrb_pkg::msg_t                  msg,
  output logic                           res_valid,
  input  logic                           res_stall,
  output wrb_pkg::res_t                  res
);

  import wrb_pkg::*;

  localparam int WIDX  = $clog2(MAX_WORKERS);
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int NW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int TW    = (LOAD_BITS > 16) ? LOAD_BITS : 16;

  state_t state, state_next;

  logic [4:0]  active_workers;
  logic [7:0]  report_step;
  logic [15:0] finish_threshold;

  logic             act_q;
  logic [3:0]       src_q;
  logic [WIDX-1:0]  src_idx;
  logic [WIDX-1:0]  idx, idx_next;
  logic [WIDX-1:0]  scan_idx;
  logic             scan_vld;
  logic [LOAD_BITS-1:0] best, best_next;
  logic [WIDX-1:0]  pick, pick_next;

  logic [MAX_WORKERS-1:0] finished_mark;
  logic [CNT_W-1:0]       finished_total, finished_total_next;

  logic [NW-1:0]    act_ext;
  logic [CNT_W-1:0] n_eff;
  logic             src_ok;
  logic             scan_last;

  logic                 mem_wr_en;
  logic [WIDX-1:0]      mem_rd_addr;
  logic [LOAD_BITS-1:0] mem_rd_data;
  logic [LOAD_BITS:0]   sat_sum;
  logic [LOAD_BITS-1:0] sat_val;

  logic finish;
  logic can_load;
  logic decide_go;
  res_t res_next;

  // Effective worker count: zero used as one, clamped to MAX_WORKERS.
  always_comb begin
    act_ext = NW'(active_workers);
    if (act_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (act_ext > NW'(MAX_WORKERS)) begin
      n_eff = CNT_W'(MAX_WORKERS);
    end else begin
      n_eff = CNT_W'(act_ext);
    end
  end

  assign src_idx   = WIDX'(src_q);
  assign src_ok    = NW'(src_q) < NW'(n_eff);
  assign scan_last = (CNT_W'(idx) + CNT_W'(1)) == n_eff;

  assign sat_sum = {1'b0, mem_rd_data} + (LOAD_BITS+1)'(report_step);
  assign sat_val = sat_sum[LOAD_BITS] ? '1 : sat_sum[LOAD_BITS-1:0];

  wrb_load_mem #(
    .DEPTH(MAX_WORKERS),
    .WIDTH(LOAD_BITS)
  ) u_load_mem (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (mem_wr_en),
    .wr_addr(src_idx),
    .wr_data(sat_val),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // Running minimum over the read-back counts.
  always_comb begin
    best_next = best;
    pick_next = pick;
    if (scan_vld) begin
      if (scan_idx == '0) begin
        best_next = mem_rd_data;
        pick_next = '0;
      end else if (scan_idx != src_idx && !finished_mark[scan_idx] &&
                   mem_rd_data < best) begin
        best_next = mem_rd_data;
        pick_next = scan_idx;
      end
    end
  end

  assign can_load = !res_valid || !res_stall;
  assign finish   = (pick == src_idx) || (TW'(best) > TW'(finish_threshold)) ||
                    finished_mark[pick];

  always_comb begin
    finished_total_next = finished_total;
    if (finish && finished_total < CNT_W'(MAX_WORKERS)) begin
      finished_total_next = finished_total + CNT_W'(1);
    end
    res_next.verdict      = finish ? VERDICT_FINISH : VERDICT_FORWARD;
    res_next.target       = finish ? src_q : 4'(pick);
    res_next.requester    = src_q;
    res_next.all_finished = finished_total_next >= n_eff;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    mem_rd_addr = idx;
    mem_wr_en   = 1'b0;
    decide_go   = 1'b0;
    msg_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        msg_stall = 1'b0;
        if (msg_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        mem_rd_addr = src_idx;
        idx_next    = '0;
        if (!src_ok) begin
          state_next = ST_IDLE;
        end else if (act_q == ACT_REPORT) begin
          state_next = ST_RPT_WR;
        end else if (finished_mark[src_idx]) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_RPT_WR: begin
        mem_wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_SCAN_END;
        end else begin
          idx_next = idx + WIDX'(1);
        end
      end
      ST_SCAN_END: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (can_load) begin
          decide_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers   <= RST_ACTIVE_WORKERS;
      report_step      <= RST_REPORT_STEP;
      finish_threshold <= RST_FINISH_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_WORKERS:   active_workers   <= cfg_data[4:0];
        REG_REPORT_STEP:      report_step      <= cfg_data[7:0];
        REG_FINISH_THRESHOLD: finish_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld       <= 1'b0;
      finished_mark  <= '0;
      finished_total <= '0;
      res_valid      <= 1'b0;
    end else begin
      scan_vld <= (state == ST_SCAN);
      if (decide_go) begin
        res_valid <= 1'b1;
        if (finish) begin
          finished_mark[src_idx] <= 1'b1;
        end
        finished_total <= finished_total_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && msg_valid) begin
      act_q <= msg.action;
      src_q <= msg.source;
    end
    idx      <= idx_next;
    scan_idx <= idx;
    best     <= best_next;
    pick     <= pick_next;
    if (decide_go) begin
      res <= res_next;
    end
  end

  a_total_matches_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(finished_mark) == 32'(finished_total))
    else $error("finished total out of step with finish marks");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_DECIDE)
    else $error("result raised outside decision step");

  a_forward_not_self: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.verdict == VERDICT_FORWARD |-> res.target != res.requester)
    else $error("request forwarded to its own requester");

  a_report_no_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_RPT_WR |=> !$rose(res_valid))
    else $error("progress report produced a result");

endmodule

>>> dv/tb_work_request_balancer.sv
// Self-checking testbench for work_request_balancer: a directed table, then random traffic,
// each result checked against its table row or a cycle-free predictor of counts and marks.
// Depends on wrb_pkg and the RTL of work_request_balancer.
module tb_work_request_balancer;
  import wrb_pkg::*;

  localparam int WORKERS = DEF_MAX_WORKERS;
  localparam int unsigned LOAD_MAX = (1 << DEF_LOAD_BITS) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    msg_t                  m;
    bit                    typed;
    res_t                  want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic msg_valid;
  logic msg_stall;
  msg_t msg;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  work_request_balancer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // predictor state
  logic [DEF_LOAD_BITS-1:0] load_cnt [WORKERS];
  bit done_mark [WORKERS];
  int unsigned done_total;
  logic [4:0] cfg_workers;
  logic [7:0] cfg_step;
  logic [15:0] cfg_thresh;
  int unsigned live_items = 0;

  res_t routed_q [$];
  plan_row_t plan [24];

  int cycles = 0;
  int errors = 0;
  bit calm = 1'b0;
  int hold_calls = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[work_request_balancer] ERROR");
      $finish;
    end
  end

  function automatic int unsigned workers_in_use();
    if (cfg_workers == 0) return 1;
    if (cfg_workers > WORKERS) return WORKERS;
    return cfg_workers;
  endfunction

  function automatic bit route_message(input msg_t m, output res_t r);
    int unsigned n;
    int unsigned pick;
    int unsigned sum;
    int unsigned i;
    logic [DEF_LOAD_BITS-1:0] best;
    bit fin;
    r = '0;
    n = workers_in_use();
    if (m.source >= n) return 1'b0;
    if (m.action == ACT_REPORT) begin
      live_items++;
      sum = load_cnt[m.source] + cfg_step;
      load_cnt[m.source] = (sum > LOAD_MAX) ? '1 : sum[DEF_LOAD_BITS-1:0];
      return 1'b0;
    end
    if (done_mark[m.source]) return 1'b0;
    live_items++;
    pick = 0;
    best = load_cnt[0];
    for (i = 1; i < n; i++) begin
      if (i != m.source && !done_mark[i] && load_cnt[i] < best) begin
        best = load_cnt[i];
        pick = i;
      end
    end
    fin = (pick == m.source) || (best > cfg_thresh) || done_mark[pick];
    if (fin) begin
      done_mark[m.source] = 1'b1;
      if (done_total < WORKERS) done_total++;
      r.verdict = VERDICT_FINISH;
      r.target = m.source;
    end else begin
      r.verdict = VERDICT_FORWARD;
      r.target = 4'(pick);
    end
    r.requester = m.source;
    r.all_finished = (done_total >= n);
    return 1'b1;
  endfunction

  function automatic plan_row_t row_msg(input logic act, input logic [3:0] src);
    plan_row_t r;
    r = '0;
    r.m.action = act;
    r.m.source = src;
    return r;
  endfunction

  function automatic plan_row_t row_answer(input logic [3:0] src, input logic verdict,
                                           input logic [3:0] target, input logic all_done);
    plan_row_t r;
    r = row_msg(ACT_REQUEST, src);
    r.typed = 1'b1;
    r.want.verdict = verdict;
    r.want.target = target;
    r.want.requester = src;
    r.want.all_finished = all_done;
    return r;
  endfunction

  function automatic plan_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    if (errors < 40) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (routed_q.size() == 0) begin
      note_mismatch($sformatf("result %h with no transaction pending", got));
      return;
    end
    want = routed_q.pop_front();
    if (got.verdict !== want.verdict)
      note_mismatch($sformatf("requester %0d verdict %b, expected %b",
                              want.requester, got.verdict, want.verdict));
    if (got.target !== want.target)
      note_mismatch($sformatf("requester %0d target %0d, expected %0d",
                              want.requester, got.target, want.target));
    if (got.requester !== want.requester)
      note_mismatch($sformatf("requester %0d, expected %0d", got.requester, want.requester));
    if (got.all_finished !== want.all_finished)
      note_mismatch($sformatf("requester %0d all_finished %b, expected %b",
                              want.requester, got.all_finished, want.all_finished));
  endtask

  // result side: check, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (res_valid && !res_stall) check_result(res);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (hold_seen != hold_calls) begin
      hold_seen <= hold_calls;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !calm && ($urandom_range(0, 99) < 21);
    end
  end

  task automatic offer(input msg_t m, input bit typed, input res_t want);
    res_t r;
    msg <= m;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    if (route_message(m, r)) routed_q.push_back(typed ? want : r);
  endtask

  task automatic sender_pause();
    if (!calm && $urandom_range(0, 99) < 21) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    msg_valid <= 1'b0;
    while (routed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACTIVE_WORKERS:   cfg_workers = value[4:0];
      REG_REPORT_STEP:      cfg_step = value[7:0];
      REG_FINISH_THRESHOLD: cfg_thresh = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    msg_t m;
    int ph;
    int roll;
    int unsigned n;
    int unsigned goal;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    msg_valid <= 1'b0;
    msg <= '0;
    cfg_workers = RST_ACTIVE_WORKERS;
    cfg_step = RST_REPORT_STEP;
    cfg_thresh = RST_FINISH_THRESHOLD;
    done_total = 0;
    foreach (load_cnt[k]) begin
      load_cnt[k] = '0;
      done_mark[k] = 1'b0;
    end
    plan = '{
      row_answer(4'd3, VERDICT_FORWARD, 4'd0, 1'b0),
      row_msg(ACT_REPORT, 4'd0),
      row_msg(ACT_REPORT, 4'd15),
      row_msg(ACT_REQUEST, 4'd15),
      row_write(REG_ACTIVE_WORKERS, 16'd2),
      row_write(REG_FINISH_THRESHOLD, 16'd0),
      row_answer(4'd1, VERDICT_FINISH, 4'd1, 1'b0),  // donor count over threshold
      row_answer(4'd0, VERDICT_FINISH, 4'd0, 1'b1),  // pick is the requester
      row_msg(ACT_REQUEST, 4'd0),                     // finished requester
      row_msg(ACT_REPORT, 4'd0),                      // finished worker still counts
      row_msg(ACT_REQUEST, 4'd5),                     // source not in use
      row_write(REG_ACTIVE_WORKERS, 16'd0),
      row_msg(ACT_REPORT, 4'd1),
      row_msg(ACT_REQUEST, 4'd0),
      row_write(REG_ACTIVE_WORKERS, 16'd3),
      row_write(REG_FINISH_THRESHOLD, 16'd65535),
      row_answer(4'd2, VERDICT_FINISH, 4'd2, 1'b1),  // pick already finished
      row_write(REG_ACTIVE_WORKERS, 16'd31),
      row_write(REG_REPORT_STEP, 16'd255),
      row_msg(ACT_REPORT, 4'd3),
      row_msg(ACT_REQUEST, 4'd4),
      row_write(REG_REPORT_STEP, 16'd0),
      row_msg(ACT_REPORT, 4'd6),
      row_msg(ACT_REQUEST, 4'd14)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        settle();
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        offer(plan[k].m, plan[k].typed, plan[k].want);
        sender_pause();
      end
    end

    // phase 0 drives worker 0 into saturation; phase 7 uses a low threshold
    for (ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0) begin
        write_reg(REG_ACTIVE_WORKERS, 16'd2);
        write_reg(REG_REPORT_STEP, 16'd255);
      end else begin
        write_reg(REG_ACTIVE_WORKERS,
                  (ph == 5) ? 16'd31 : (ph == 3) ? 16'd16 : 16'($urandom_range(8, 16)));
        write_reg(REG_REPORT_STEP, 16'($urandom_range(0, 255)));
        write_reg(REG_FINISH_THRESHOLD,
                  (ph == 7) ? 16'($urandom_range(0, 400)) : 16'($urandom_range(8000, 65535)));
      end
      calm <= (ph == 1);
      if (ph == 2) hold_calls <= hold_calls + 1;
      n = workers_in_use();
      goal = live_items + ((ph == 0) ? 300 : 100);
      while (live_items < goal) begin
        roll = $urandom_range(0, 99);
        if (ph == 0) begin
          m.action = (roll < 95) ? ACT_REPORT : ACT_REQUEST;
          m.source = (roll < 95) ? 4'd0 : 4'($urandom_range(0, 15));
        end else if (roll < 10) begin
          m.action = 1'($urandom_range(0, 1));
          m.source = 4'($urandom_range(0, 15));
        end else begin
          m.action = (roll < 45) ? ACT_REPORT : ACT_REQUEST;
          m.source = 4'($urandom_range(0, n - 1));
        end
        offer(m, 1'b0, '0);
        sender_pause();
      end
    end
    settle();

    if (errors == 0) begin
      $display("[work_request_balancer] OK");
    end else begin
      $display("[work_request_balancer] ERROR");
    end
    $finish;
  end

endmodule
